### hdl/shep_pkg.sv
// Shared constants and types of the Shepard tone wavetable oscillator.
package shep_pkg;

   localparam int PHASE_FRAC = 12;
   localparam int PHASE_W    = 25;

   localparam logic [31:0] RATE_ONE = 32'h4000_0000;
   localparam logic [31:0] RATE_TWO = 32'h8000_0000;

   localparam logic [1:0]  MODE_RESET  = 2'd0;
   localparam logic [30:0] DELTA_RESET = 31'd1073743614;
   localparam logic [14:0] LEVEL_RESET = 15'd1983;

   localparam logic [1:0] MODE_TONE = 2'd0;
   localparam logic [1:0] MODE_RING = 2'd1;
   localparam logic [1:0] MODE_MIX  = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_DELTA = 2'd1;
   localparam logic [1:0] CSR_LEVEL = 2'd2;

   localparam logic signed [33:0] SAT_MAX = 34'sd8388607;
   localparam logic signed [33:0] SAT_MIN = -34'sd8388608;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_MUL_RATE = 14'b00000000000010,
      ST_FOLD     = 14'b00000000000100,
      ST_ADV      = 14'b00000000001000,
      ST_RD1      = 14'b00000000010000,
      ST_LD1      = 14'b00000000100000,
      ST_MUL_T1   = 14'b00000001000000,
      ST_MUL_T2   = 14'b00000010000000,
      ST_MUL_I1   = 14'b00000100000000,
      ST_MUL_I2   = 14'b00001000000000,
      ST_MUL_LVL  = 14'b00010000000000,
      ST_DIV      = 14'b00100000000000,
      ST_MUL_RING = 14'b01000000000000,
      ST_OUT      = 14'b10000000000000
   } state_type;

endpackage

### hdl/shepard_tone_wavetable_osc.sv
// Shepard tone wavetable oscillator: one mono sample per stereo input transaction.
// One transaction is processed at a time: req_tready is high only in ST_IDLE, and ST_OUT waits
// while a previous response is still held by low rsp_tready. Each tick runs one bit-serial
// multiplier for six products (plus one more in ring modulation mode) and a bit-serial divider,
// all in sequence on the shared hi/low registers.
// Synchronous reset: phase to zero, rate to one, registers to defaults; the tables are ROM.
module shepard_tone_wavetable_osc #(
   parameter int TABLE_SIZE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] in_left, [47:24] in_right
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] out_sample
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import shep_pkg::*;

   localparam int TBL_N = TABLE_SIZE - 1;
   localparam int AW    = $clog2(TABLE_SIZE);
   localparam logic [25:0] MAXP = 26'(TBL_N) << PHASE_FRAC;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef logic signed [17:0] rom_type [TABLE_SIZE];

   // sin(2*pi*k/TBL_N) in Q2.30 by quarter-wave folding and a Taylor series
   function automatic longint sine_q30(input longint k);
      longint t, x, th, th2, term, sm;
      t = (k << 32) / TBL_N;
      x = t & 64'h3FFF_FFFF;
      if (t[30]) x = 64'h4000_0000 - x;
      th   = (x * HALF_PI_Q30) >>> 30;
      th2  = (th * th) >>> 30;
      term = th;
      sm   = th;
      term = ((term * th2) >>> 30) / 6;
      sm   = sm - term;
      term = ((term * th2) >>> 30) / 20;
      sm   = sm + term;
      term = ((term * th2) >>> 30) / 42;
      sm   = sm - term;
      term = ((term * th2) >>> 30) / 72;
      sm   = sm + term;
      return t[31] ? -sm : sm;
   endfunction

   function automatic rom_type build_rom(input logic want_oct);
      rom_type t;
      longint  acc, s, sn;
      for (int k = 0; k < TBL_N; k++) begin
         acc = 0;
         sn  = 0;
         for (int i = 0; i < 8; i++) begin
            s   = sine_q30((longint'(k) << i) % TBL_N);
            acc = acc + (s >>> i);
            if (i == 0) sn = (s + 16384) >>> 15;
         end
         t[k] = want_oct ? 18'((acc + 16384) >>> 15) : 18'(sn);
      end
      t[TBL_N] = '0;
      return t;
   endfunction

   localparam rom_type OCT_ROM  = build_rom(1'b1);
   localparam rom_type SINE_ROM = build_rom(1'b0);

   state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [30:0] delta_ff, delta_in;
   logic [14:0] level_ff, level_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [31:0] rate_ff, rate_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic signed [24:0] a_ff, a_in;
   logic signed [33:0] mcand_ff, mcand_in;
   logic signed [34:0] hi_ff, hi_in;
   logic [31:0]        low_ff, low_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [17:0] oct1_ff, oct1_in;
   logic signed [19:0] tap1_ff, tap1_in;
   logic signed [19:0] tap2_ff, tap2_in;
   logic signed [33:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] y_ff, y_in;
   logic [AW-1:0]      i1_ff, i1_in, i2_ff, i2_in;
   logic [PHASE_FRAC-1:0] f_ff, f_in;

   logic signed [17:0] oct_q_ff, sin_q_ff;
   logic [AW-1:0]      rom_addr;

   logic signed [66:0] prod;
   logic signed [34:0] m_ext, addend, msum;
   logic [32:0]        rem2, rdiv, rem_next;
   logic               take;
   logic [31:0]        r0, r1;
   logic [25:0]        p1, p2, p3;
   logic [AW-1:0]      idx, i1v;
   logic signed [33:0] fade;
   logic signed [34:0] bsum;
   logic signed [35:0] pm;
   logic [35:0]        nmag;
   logic signed [33:0] qv, yv;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign prod   = {hi_ff, low_ff};
   assign m_ext  = 35'(mcand_ff);
   assign addend = low_ff[0] ? ((cnt_ff == 6'd1) ? -m_ext : m_ext) : '0;
   assign msum   = hi_ff + addend;

   assign rem2     = {hi_ff[31:0], low_ff[29]};
   assign rdiv     = {1'b0, rate_ff};
   assign take     = (rem2 >= rdiv);
   assign rem_next = rem2 - rdiv;

   assign fade     = $signed({2'b00, rate_ff}) - 34'sd2147483648;
   assign rom_addr = (state_ff == ST_RD1) ? i1_ff : i2_ff;

   always_ff @(posedge clock) begin
      oct_q_ff <= OCT_ROM[rom_addr];
      sin_q_ff <= SINE_ROM[rom_addr];
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      delta_in     = delta_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      a_in         = a_ff;
      mcand_in     = mcand_ff;
      hi_in        = hi_ff;
      low_in       = low_ff;
      cnt_in       = cnt_ff;
      oct1_in      = oct1_ff;
      tap1_in      = tap1_ff;
      tap2_in      = tap2_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      y_in         = y_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      f_in         = f_ff;

      r0   = prod[61:30];
      r1   = r0;
      p2   = {phase_ff, 1'b0};
      p1   = {1'b0, phase_ff};
      p3   = {1'b0, phase_ff} + 26'(rate_ff[31:30-PHASE_FRAC]);
      if (p3 > MAXP) p3 = p3 - MAXP;
      idx  = p3[PHASE_FRAC +: AW];
      i1v  = (idx == AW'(TBL_N)) ? '0 : idx;
      bsum = 35'(acc_ff) + 35'($signed(prod[33:0]));
      pm   = $signed(prod[35:0]);
      nmag = pm[35] ? 36'(-pm) : 36'(pm);
      qv   = $signed({4'b0000, low_ff[29:0]});
      yv   = neg_ff ? -qv : qv;

      if (r0 > RATE_TWO) begin
         r1 = r0 >> 1;
         p1 = {2'b00, phase_ff[PHASE_W-1:1]};
      end else if (r0 < RATE_ONE) begin
         r1 = r0 << 1;
         p1 = (p2 >= MAXP) ? (p2 - MAXP) : p2;
      end
      if (r1 < RATE_ONE) r1 = RATE_ONE;
      if (r1 > RATE_TWO) r1 = RATE_TWO;

      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            CSR_DELTA: delta_in = csr_wdata;
            CSR_LEVEL: level_in = csr_wdata[14:0];
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_in     = $signed(req_tdata[23:0]) + $signed(req_tdata[47:24]);
               mcand_in = $signed({2'b00, rate_ff});
               hi_in    = '0;
               low_in   = {1'b0, delta_ff};
               cnt_in   = 6'd32;
               state_in = ST_MUL_RATE;
            end
         end
         ST_FOLD: begin
            rate_in  = r1;
            phase_in = p1[PHASE_W-1:0];
            state_in = ST_ADV;
         end
         ST_ADV: begin
            phase_in = p3[PHASE_W-1:0];
            i1_in    = i1v;
            i2_in    = i1v + 1'b1;
            f_in     = p3[PHASE_FRAC-1:0];
            state_in = ST_RD1;
         end
         ST_RD1: state_in = ST_LD1;
         ST_LD1: begin
            oct1_in  = oct_q_ff;
            mcand_in = fade;
            hi_in    = '0;
            low_in   = 32'(sin_q_ff);
            cnt_in   = 6'd32;
            state_in = ST_MUL_T1;
         end
         ST_MUL_RATE, ST_MUL_T1, ST_MUL_T2, ST_MUL_I1, ST_MUL_I2, ST_MUL_LVL,
         ST_MUL_RING: begin
            if (cnt_ff != 6'd0) begin
               hi_in  = msum >>> 1;
               low_in = {msum[0], low_ff[31:1]};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               hi_in  = '0;
               cnt_in = 6'd32;
               case (state_ff)
                  ST_MUL_RATE: begin
                     // hold the product for the fold
                     hi_in    = hi_ff;
                     state_in = ST_FOLD;
                  end
                  ST_MUL_T1: begin
                     tap1_in  = 20'(oct1_ff) + $signed(prod[49:30]);
                     low_in   = 32'(sin_q_ff);
                     state_in = ST_MUL_T2;
                  end
                  ST_MUL_T2: begin
                     tap2_in  = 20'(oct_q_ff) + $signed(prod[49:30]);
                     mcand_in = 34'(tap1_ff);
                     low_in   = {19'd0, 13'(13'd4096 - {1'b0, f_ff})};
                     state_in = ST_MUL_I1;
                  end
                  ST_MUL_I1: begin
                     acc_in   = $signed(prod[33:0]);
                     mcand_in = 34'(tap2_ff);
                     low_in   = {20'd0, f_ff};
                     state_in = ST_MUL_I2;
                  end
                  ST_MUL_I2: begin
                     mcand_in = 34'(bsum >>> PHASE_FRAC);
                     low_in   = {17'd0, level_ff};
                     state_in = ST_MUL_LVL;
                  end
                  ST_MUL_LVL: begin
                     // numerator is |b*level| << 26; its top part already sits below rate
                     neg_in   = pm[35];
                     hi_in    = $signed({3'b000, nmag[35:4]});
                     low_in   = {2'b00, nmag[3:0], 26'd0};
                     cnt_in   = 6'd30;
                     state_in = ST_DIV;
                  end
                  default: begin
                     y_in     = prod[56:23];
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (cnt_ff != 6'd0) begin
               hi_in  = take ? $signed({2'b00, rem_next}) : $signed({2'b00, rem2});
               low_in = {low_ff[30:0], take};
               cnt_in = cnt_ff - 1'b1;
            end else if (mode_ff == MODE_RING) begin
               mcand_in = yv;
               hi_in    = '0;
               low_in   = 32'(a_ff);
               cnt_in   = 6'd32;
               state_in = ST_MUL_RING;
            end else begin
               y_in     = (mode_ff == MODE_MIX) ? (yv + 34'(a_ff >>> 1)) : yv;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (y_ff > SAT_MAX)      rsp_data_in = SAT_MAX[23:0];
               else if (y_ff < SAT_MIN) rsp_data_in = SAT_MIN[23:0];
               else                     rsp_data_in = y_ff[23:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         delta_ff     <= DELTA_RESET;
         level_ff     <= LEVEL_RESET;
         phase_ff     <= '0;
         rate_ff      <= RATE_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         delta_ff     <= delta_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      a_ff        <= a_in;
      mcand_ff    <= mcand_in;
      hi_ff       <= hi_in;
      low_ff      <= low_in;
      cnt_ff      <= cnt_in;
      oct1_ff     <= oct1_in;
      tap1_ff     <= tap1_in;
      tap2_ff     <= tap2_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      y_ff        <= y_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      f_ff        <= f_in;
   end

endmodule
